// ===== sv/ffc_pkg.sv =====
package ffc_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned HALF_W = 16;

  typedef enum logic [1:0] {
    OP_F32_TO_F16  = 2'd0,
    OP_F16_TO_F32  = 2'd1,
    OP_F32_TO_BF16 = 2'd2,
    OP_BF16_TO_F32 = 2'd3
  } opcode_t;

  // Single precision exponent thresholds, expressed against the biased fp32 exponent
  localparam logic [7:0] F32_EXP_MAX     = 8'hFF;
  localparam logic [7:0] F32_TO_F16_ADJ  = 8'd112;  // 127 - 15
  localparam logic [7:0] F16_OVF_EXP     = 8'd143;  // half exponent reaches 31
  localparam logic [7:0] F16_SUB_MIN_EXP = 8'd102;  // below this the half result is zero
  localparam logic [7:0] F16_SUB_SH_BASE = 8'd113;  // shift = 113 - exp
  localparam logic [7:0] F16_SUB_EXP_LO  = 8'd103;  // fp32 exponent of a half subnormal, bit 0
  localparam logic [4:0] F16_EXP_MAX     = 5'h1F;
  localparam logic [31:0] BF16_RND_BIAS  = 32'h0000_7FFF;

endpackage

// ===== sv/ffc_convert.sv =====
module ffc_convert (
  input  ffc_pkg::opcode_t                opcode,
  input  logic [ffc_pkg::VAL_W-1:0]       value_in,
  output logic [ffc_pkg::VAL_W-1:0]       value_out
);
  import ffc_pkg::*;

  // fp32 fields
  logic        s32;
  logic [7:0]  e32;
  logic [22:0] m32;
  logic [3:0]  sub_sh;
  logic [23:0] sub_man;
  logic [15:0] to_half;

  // fp16 fields
  logic        s16;
  logic [4:0]  e16;
  logic [9:0]  m16;
  logic [3:0]  top_pos;
  logic [3:0]  norm_sh;
  logic [9:0]  norm_man;
  logic [31:0] from_half;

  logic [31:0] bf_sum;

  assign s32 = value_in[31];
  assign e32 = value_in[30:23];
  assign m32 = value_in[22:0];

  // Only meaningful for exponents 102..112, giving shifts 1..11
  assign sub_sh  = 4'(F16_SUB_SH_BASE - e32);
  assign sub_man = {1'b1, m32} >> sub_sh;

  always_comb begin
    if (e32 == 8'd0) begin
      to_half = {s32, 15'd0};
    end else if (e32 == F32_EXP_MAX) begin
      to_half = {s32, F16_EXP_MAX, (|m32), 9'd0};
    end else if (e32 >= F16_OVF_EXP) begin
      to_half = {s32, F16_EXP_MAX, 10'd0};
    end else if (e32 < F16_SUB_MIN_EXP) begin
      to_half = {s32, 15'd0};
    end else if (e32 <= F32_TO_F16_ADJ) begin
      to_half = {s32, 5'd0, sub_man[22:13]};
    end else begin
      to_half = {s32, 5'(e32 - F32_TO_F16_ADJ), m32[22:13]};
    end
  end

  assign s16 = value_in[15];
  assign e16 = value_in[14:10];
  assign m16 = value_in[9:0];

  // Position of the leading one in a subnormal half mantissa
  always_comb begin
    top_pos = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m16[i]) begin
        top_pos = 4'(i);
      end
    end
  end

  assign norm_sh  = 4'd10 - top_pos;
  assign norm_man = 10'({1'b0, m16} << norm_sh);

  always_comb begin
    if (e16 == 5'd0) begin
      if (m16 == 10'd0) begin
        from_half = {s16, 31'd0};
      end else begin
        from_half = {s16, F16_SUB_EXP_LO + {4'd0, top_pos}, norm_man, 13'd0};
      end
    end else if (e16 == F16_EXP_MAX) begin
      from_half = {s16, F32_EXP_MAX, m16, 13'd0};
    end else begin
      from_half = {s16, {3'd0, e16} + F32_TO_F16_ADJ, m16, 13'd0};
    end
  end

  // Round to nearest even; the add wraps at 32 bits
  assign bf_sum = value_in + BF16_RND_BIAS + {31'd0, value_in[16]};

  always_comb begin
    case (opcode)
      OP_F32_TO_F16:  value_out = {16'd0, to_half};
      OP_F16_TO_F32:  value_out = from_half;
      OP_F32_TO_BF16: value_out = {16'd0, bf_sum[31:16]};
      OP_BF16_TO_F32: value_out = {value_in[15:0], 16'd0};
      default:        value_out = '0;
    endcase
  end

endmodule

// ===== sv/float_format_converter.sv =====
// Channel   Ports                                      Direction
// input     in_valid, in_ready, in_opcode, in_value_in  into the block
// result    out_valid, out_ready, out_value_out         out of the block
//
// One item per cycle sustained while out_ready stays high.
// The depth is set by the input register and the result register, with the
// conversion logic between them.
// Synchronous active-low reset empties both registers; no other state.
// A stalled result holds in the result register while the input register
// still takes one more item.
module float_format_converter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ffc_pkg::opcode_t            in_opcode,
  input  logic [ffc_pkg::VAL_W-1:0]   in_value_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ffc_pkg::VAL_W-1:0]   out_value_out
);
  import ffc_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  opcode_t           s1_op_r;
  logic [VAL_W-1:0]  s1_val_r;
  logic              s2_valid_r, s2_valid_nxt;
  logic [VAL_W-1:0]  s2_val_r;
  logic [VAL_W-1:0]  conv_val;
  logic              s2_ready;
  logic              s1_ready;

  assign s2_ready = !s2_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  assign s1_valid_nxt = (in_valid && s1_ready) || (s1_valid_r && !s2_ready);
  assign s2_valid_nxt = (s1_valid_r && s2_ready) || (s2_valid_r && !out_ready);

  ffc_convert u_convert (
    .opcode    (s1_op_r),
    .value_in  (s1_val_r),
    .value_out (conv_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_op_r  <= in_opcode;
      s1_val_r <= in_value_in;
    end
    if (s1_valid_r && s2_ready) begin
      s2_val_r <= conv_val;
    end
  end

  assign out_valid     = s2_valid_r;
  assign out_value_out = s2_val_r;

endmodule

// ===== sv/ffc_checker.sv =====
module ffc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ffc_pkg::VAL_W-1:0]   out_value_out
);

  // Result register empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input side only backs up when the result is held
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a held result");

  // An accepted item with a free output path shows up as a valid result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("item lost in flight");

  // Held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value_out)))
    else $error("stalled item changed");

endmodule

bind float_format_converter ffc_checker u_ffc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_value_out (out_value_out)
);

// ===== bench/float_format_converter_tb.sv =====
`timescale 1ns / 100ps

module float_format_converter_tb;
  import ffc_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int QUIET_ITEMS = 300;

  typedef struct packed {
    opcode_t     op;
    logic [31:0] src;
    logic        typed;
    logic [31:0] want;
  } vector_t;

  // Rows with typed set carry a result read straight off the conversion rules;
  // the rest go through the converter model.
  localparam vector_t DIRECTED [25] = '{
    '{OP_F32_TO_F16,  32'h0000_0000, 1'b1, 32'h0000_0000},
    '{OP_F32_TO_F16,  32'h8000_0001, 1'b1, 32'h0000_8000},
    '{OP_F32_TO_F16,  32'h7F80_0000, 1'b1, 32'h0000_7C00},
    '{OP_F32_TO_F16,  32'hFFC0_0001, 1'b1, 32'h0000_FE00},
    '{OP_F32_TO_F16,  32'h4780_0000, 1'b1, 32'h0000_7C00},
    '{OP_F32_TO_F16,  32'h477F_FFFF, 1'b0, 32'h0},
    '{OP_F32_TO_F16,  32'h3880_0000, 1'b0, 32'h0},
    '{OP_F32_TO_F16,  32'h387F_FFFF, 1'b0, 32'h0},
    '{OP_F32_TO_F16,  32'h3380_0000, 1'b0, 32'h0},
    '{OP_F32_TO_F16,  32'h3300_0000, 1'b0, 32'h0},
    '{OP_F32_TO_F16,  32'hB2FF_FFFF, 1'b1, 32'h0000_8000},
    '{OP_F16_TO_F32,  32'hFFFF_0000, 1'b1, 32'h0000_0000},
    '{OP_F16_TO_F32,  32'h0000_8001, 1'b0, 32'h0},
    '{OP_F16_TO_F32,  32'h0000_03FF, 1'b0, 32'h0},
    '{OP_F16_TO_F32,  32'h0000_7C00, 1'b1, 32'h7F80_0000},
    '{OP_F16_TO_F32,  32'h0000_FFFF, 1'b1, 32'hFFFF_E000},
    '{OP_F16_TO_F32,  32'h0000_7BFF, 1'b0, 32'h0},
    '{OP_F32_TO_BF16, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{OP_F32_TO_BF16, 32'h7F80_8000, 1'b0, 32'h0},
    '{OP_F32_TO_BF16, 32'h3F80_8000, 1'b0, 32'h0},
    '{OP_F32_TO_BF16, 32'h3F81_8000, 1'b0, 32'h0},
    '{OP_F32_TO_BF16, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{OP_BF16_TO_F32, 32'hABCD_FFFF, 1'b1, 32'hFFFF_0000},
    '{OP_BF16_TO_F32, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{OP_F32_TO_F16,  32'hFFFF_FFFF, 1'b1, 32'h0000_FE00}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  opcode_t             in_opcode;
  logic [VAL_W-1:0]    in_value_in;
  logic                out_valid;
  logic                out_ready;
  logic [VAL_W-1:0]    out_value_out;

  logic [31:0] expected_words [$];
  int          failures;
  int          words_checked;
  int          op_count [4];
  bit          quiet;

  float_format_converter DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_value_in   (in_value_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value_out (out_value_out)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [31:0] convert_word(opcode_t op, logic [31:0] v);
    logic [31:0] r;
    logic [31:0] sum;
    logic [23:0] wide;
    logic [10:0] mm;
    int          hexp;
    int          k;
    r = '0;
    case (op)
      OP_F32_TO_F16: begin
        hexp = int'(v[30:23]) - 112;
        if (v[30:23] == 8'h00) begin
          r = {16'b0, v[31], 15'b0};
        end else if (v[30:23] == 8'hFF) begin
          r = {16'b0, v[31], 5'h1F, |v[22:0], 9'b0};
        end else if (hexp >= 31) begin
          r = {16'b0, v[31], 5'h1F, 10'b0};
        end else if (hexp < -10) begin
          r = {16'b0, v[31], 15'b0};
        end else if (hexp <= 0) begin
          // denormalise: restore the hidden bit and shift it down
          wide = {1'b1, v[22:0]} >> (1 - hexp);
          r = {16'b0, v[31], 5'b0, wide[22:13]};
        end else begin
          r = {16'b0, v[31], hexp[4:0], v[22:13]};
        end
      end
      OP_F16_TO_F32: begin
        if (v[14:10] == 5'h00) begin
          if (v[9:0] == 10'b0) begin
            r = {v[15], 31'b0};
          end else begin
            mm = {1'b0, v[9:0]};
            k = 0;
            while (!mm[10]) begin
              mm = mm << 1;
              k++;
            end
            r = {v[15], 8'(113 - k), mm[9:0], 13'b0};
          end
        end else if (v[14:10] == 5'h1F) begin
          r = {v[15], 8'hFF, v[9:0], 13'b0};
        end else begin
          r = {v[15], 8'({3'b0, v[14:10]} + 8'd112), v[9:0], 13'b0};
        end
      end
      OP_F32_TO_BF16: begin
        // round to nearest even; the add wraps at 32 bits on purpose
        sum = v + 32'h0000_7FFF + {31'b0, v[16]};
        r = {16'b0, sum[31:16]};
      end
      default: begin
        r = {v[15:0], 16'b0};
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_source(opcode_t op);
    logic [31:0] w;
    w = $urandom();
    case (op)
      OP_F32_TO_F16: begin
        case ($urandom_range(0, 5))
          0: w[30:23] = 8'h00;
          1: w[30:23] = 8'hFF;
          2: w[30:23] = 8'($urandom_range(100, 114));
          3: w[30:23] = 8'($urandom_range(140, 144));
          default: ;
        endcase
        if ($urandom_range(0, 7) == 0) w[22:0] = '0;
      end
      OP_F32_TO_BF16: begin
        case ($urandom_range(0, 5))
          0: w[15:0] = 16'h8000;
          1: w[15:0] = 16'h7FFF;
          2: w[30:23] = 8'hFF;
          3: w[31:16] = 16'hFFFF;
          default: ;
        endcase
      end
      default: begin
        case ($urandom_range(0, 3))
          0: w[14:10] = 5'h00;
          1: w[14:10] = 5'h1F;
          default: ;
        endcase
      end
    endcase
    return w;
  endfunction

  task automatic push_item(opcode_t op, logic [31:0] src, logic typed, logic [31:0] want);
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_value_in <= src;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_words.push_back(typed ? want : convert_word(op, src));
    op_count[int'(op)]++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // result side: stall in bursts, none once the quiet tail starts
  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("value_out: no item expected, got %h", out_value_out);
        failures++;
      end else begin
        if (out_value_out !== expected_words[0]) begin
          $error("value_out: expected %h, got %h", expected_words[0], out_value_out);
          failures++;
        end
        void'(expected_words.pop_front());
        words_checked++;
      end
    end
  end

  initial begin
    #5ms;
    $display("float_format_converter verification failed");
    $finish;
  end

  initial begin
    opcode_t op;
    int      drain;
    failures = 0;
    words_checked = 0;
    quiet = 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_opcode   <= OP_F32_TO_F16;
    in_value_in <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i])
      push_item(DIRECTED[i].op, DIRECTED[i].src, DIRECTED[i].typed, DIRECTED[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      op = opcode_t'($urandom_range(0, 3));
      push_item(op, pick_source(op), 1'b0, '0);
    end
    in_valid <= 1'b0;

    drain = 0;
    while (expected_words.size() != 0 && drain < 1000) begin
      @(posedge clk);
      drain++;
    end
    if (expected_words.size() != 0) begin
      $error("value_out: %0d items never arrived", expected_words.size());
      failures++;
    end
    // watch for stray results
    repeat (8) @(posedge clk);

    $display("Checked %0d converted words: %0d fp32->fp16, %0d fp16->fp32,",
             words_checked, op_count[0], op_count[1]);
    $display("%0d fp32->bf16, %0d bf16->fp32, with stalls on both sides.",
             op_count[2], op_count[3]);
    if (failures == 0) begin
      $display("float_format_converter verification clean");
    end else begin
      $display("float_format_converter verification failed");
    end
    $finish;
  end

endmodule
